// ===== hdl/tsm_pkg.sv =====
// Shared types, sizes and value helpers for the two-set membership marker.
// Used by tsm_cell and two_set_membership_marker; depends on nothing.
package tsm_pkg;

    localparam int DEPTH       = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 5;
    localparam int FIELD_W     = 32;

    typedef struct packed {
        logic                      array_select;
        logic signed [FIELD_W-1:0] value;
        logic                      last;
    } t_in;

    typedef struct packed {
        logic                      from_array;
        logic        [POS_W-1:0]   position;
        logic signed [FIELD_W-1:0] element_value;
        logic                      in_other;
        logic                      overflow;
        logic                      last_result;
    } t_out;

    // probe travelling down the cell row
    typedef struct packed {
        logic                   valid;
        logic                   side;   // set the probe value came from
        logic [VALUE_WIDTH-1:0] value;
        logic                   hit;
    } t_probe;

    // sign-extend the field, keep the stored width
    function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic [FIELD_W-1:0] v);
        logic [63:0] ext;
        ext = {{(64 - FIELD_W){v[FIELD_W-1]}}, v};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    // stored bits back to the 32-bit field, zero padded or cut
    function automatic logic [FIELD_W-1:0] to_field(input logic [VALUE_WIDTH-1:0] s);
        logic [63:0] ext;
        ext = 64'(s);
        return ext[FIELD_W-1:0];
    endfunction

endpackage

// ===== hdl/tsm_cell.sv =====
// One cell of the membership row: holds one A and one B entry and compares a
// passing probe against the entry of the other set. Depends on tsm_pkg.
module tsm_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_a,
    input  logic                            i_wr_b,
    input  logic [tsm_pkg::VALUE_WIDTH-1:0] i_wr_data,
    input  logic                            i_a_live,
    input  logic                            i_b_live,
    input  tsm_pkg::t_probe                 i_probe,
    output tsm_pkg::t_probe                 o_probe,
    output logic [tsm_pkg::VALUE_WIDTH-1:0] o_a_val,
    output logic [tsm_pkg::VALUE_WIDTH-1:0] o_b_val
);

    logic [tsm_pkg::VALUE_WIDTH-1:0] r_a;
    logic [tsm_pkg::VALUE_WIDTH-1:0] r_b;
    tsm_pkg::t_probe                 r_probe;
    tsm_pkg::t_probe                 n_probe;
    logic                            w_match;

    // A probe checks against B, a B probe against A
    always_comb begin
        if (i_probe.side) begin
            w_match = i_a_live && (r_a == i_probe.value);
        end else begin
            w_match = i_b_live && (r_b == i_probe.value);
        end
        n_probe       = i_probe;
        n_probe.hit   = i_probe.hit | (i_probe.valid & w_match);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_a <= i_wr_data;
        end
        if (i_wr_b) begin
            r_b <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.side  <= n_probe.side;
        r_probe.value <= n_probe.value;
        r_probe.hit   <= n_probe.hit;
    end

    assign o_probe = r_probe;
    assign o_a_val = r_a;
    assign o_b_val = r_b;

endmodule

// ===== hdl/two_set_membership_marker.sv =====
// Two-set membership marker: loads sets A and B, then marks shared values.
// Load: one input beat per cycle, no result until the beat flagged last.
// Emission: each result passes through launch, the DEPTH cells of the compare
// row and present, and waits out any output stall; results go out one at a time.
// Reset (i_rst_n low, synchronous) empties both sets and clears overflow;
// stored entries are not cleared, only entries below the counts are read.
module two_set_membership_marker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tsm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tsm_pkg::t_out o_out_data
);

    localparam logic [1:0] S_LOAD   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_SHOW   = 2'd3;

    localparam int D  = tsm_pkg::DEPTH;
    localparam int CW = tsm_pkg::CNT_W;
    localparam int IW = tsm_pkg::IDX_W;
    localparam int VW = tsm_pkg::VALUE_WIDTH;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_cnt_a, n_cnt_a;
    logic [CW-1:0]   r_cnt_b, n_cnt_b;
    logic            r_ovf,   n_ovf;
    logic            r_side,  n_side;   // set currently being reported
    logic [IW-1:0]   r_pos,   n_pos;    // element index within that set
    tsm_pkg::t_out   r_out,   n_out;

    logic            w_in_acc;
    logic            w_out_acc;
    logic [VW-1:0]   w_wr_data;
    logic [D-1:0]    w_wr_a;
    logic [D-1:0]    w_wr_b;
    logic [D-1:0]    w_a_live;
    logic [D-1:0]    w_b_live;
    logic [D-1:0]    w_pvalid;
    logic [VW-1:0]   w_a_val [D];
    logic [VW-1:0]   w_b_val [D];
    tsm_pkg::t_probe w_chain_in [D];
    tsm_pkg::t_probe w_probe    [D];
    tsm_pkg::t_probe w_head;
    tsm_pkg::t_probe w_tail;
    logic            w_a_end;
    logic            w_b_end;
    logic            w_is_last;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_SHOW);
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_wr_data   = tsm_pkg::to_stored(i_in_data.value);

    // probe injected at the head of the row while launching
    always_comb begin
        w_head.valid = (r_state == S_LAUNCH);
        w_head.side  = r_side;
        w_head.value = r_side ? w_b_val[r_pos] : w_a_val[r_pos];
        w_head.hit   = 1'b0;
    end

    // compare row: cell k holds entry k of both sets
    for (genvar k = 0; k < D; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_chain_in[k] = w_head;
        end else begin : g_link
            assign w_chain_in[k] = w_probe[k-1];
        end

        // next free slot takes the beat; a full set matches no cell
        assign w_wr_a[k]   = w_in_acc && !i_in_data.array_select && (r_cnt_a == CW'(k));
        assign w_wr_b[k]   = w_in_acc &&  i_in_data.array_select && (r_cnt_b == CW'(k));
        assign w_a_live[k] = (CW'(k) < r_cnt_a);
        assign w_b_live[k] = (CW'(k) < r_cnt_b);
        assign w_pvalid[k] = w_probe[k].valid;

        tsm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_a    (w_wr_a[k]),
            .i_wr_b    (w_wr_b[k]),
            .i_wr_data (w_wr_data),
            .i_a_live  (w_a_live[k]),
            .i_b_live  (w_b_live[k]),
            .i_probe   (w_chain_in[k]),
            .o_probe   (w_probe[k]),
            .o_a_val   (w_a_val[k]),
            .o_b_val   (w_b_val[k])
        );
    end

    assign w_tail    = w_probe[D-1];
    assign w_a_end   = ((CW'(r_pos) + CW'(1)) == r_cnt_a);
    assign w_b_end   = ((CW'(r_pos) + CW'(1)) == r_cnt_b);
    // final result: last B element, or last A element when B is empty
    assign w_is_last = r_side ? w_b_end : (w_a_end && (r_cnt_b == '0));

    always_comb begin
        n_state = r_state;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_ovf   = r_ovf;
        n_side  = r_side;
        n_pos   = r_pos;
        n_out   = r_out;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (!i_in_data.array_select) begin
                        if (r_cnt_a < CW'(D)) begin
                            n_cnt_a = r_cnt_a + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        if (r_cnt_b < CW'(D)) begin
                            n_cnt_b = r_cnt_b + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_in_data.last) begin
                        if ((n_cnt_a == '0) && (n_cnt_b == '0)) begin
                            // nothing stored: start afresh, no results
                            n_ovf = 1'b0;
                        end else begin
                            n_state = S_LAUNCH;
                            n_side  = (n_cnt_a == '0);
                            n_pos   = '0;
                        end
                    end
                end
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_tail.valid) begin
                    n_out.from_array    = r_side;
                    n_out.position      = tsm_pkg::POS_W'(r_pos);
                    n_out.element_value = tsm_pkg::to_field(w_tail.value);
                    n_out.in_other      = w_tail.hit;
                    n_out.overflow      = r_ovf;
                    n_out.last_result   = w_is_last;
                    n_state             = S_SHOW;
                end
            end
            S_SHOW: begin
                if (w_out_acc) begin
                    if (r_out.last_result) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_LAUNCH;
                        // A done: move on to the first B element
                        if (!r_side && w_a_end) begin
                            n_side = 1'b1;
                            n_pos  = '0;
                        end else begin
                            n_pos = r_pos + IW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
            r_side  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ovf   <= n_ovf;
            r_side  <= n_side;
            r_pos   <= n_pos;
        end
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // load and emission never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is shown");

    // only one probe in the row at a time
    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_pvalid) <= 1)
        else $error("more than one probe in the compare row");

    // a probe leaves the row only while it is awaited
    a_tail_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == S_WAIT))
        else $error("probe left the row outside the wait state");

    // the final result empties both sets
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_out.last_result) |=> (r_cnt_a == '0 && r_cnt_b == '0 && !r_ovf))
        else $error("sets not emptied after the final result");
`endif

endmodule
